@@ src/aenv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package aenv_pkg;

   localparam int LEVEL_BITS = 24;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_DATA_BITS-1:0] TICKS_RESET = 32'd4800;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ATTACK_TICKS  = 1'b0,
      CSR_RELEASE_TICKS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_ON   = 2'd1,
      PHASE_OFF  = 2'd2
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIV    = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_HOLD   = 4'b1000
   } seq_state_type;

endpackage

`default_nettype wire

@@ src/aenv_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface aenv_req_if;
   logic valid;
   logic ready;
   logic trigger;

   modport source (output valid, output trigger, input ready);
   modport sink (input valid, input trigger, output ready);
endinterface

interface aenv_rsp_if
   import aenv_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic [LEVEL_BITS-1:0] level;

   modport source (output valid, output level, input ready);
   modport sink (input valid, input level, output ready);
endinterface

`default_nettype wire

@@ src/aenv_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aenv_div
   import aenv_pkg::*;
#(
   parameter int LEVEL_FRAC_BITS = 23,
   parameter int TICK_BITS = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [TICK_BITS-1:0]       divisor,
   output logic                            done,
   output logic [LEVEL_FRAC_BITS:0]        quotient
);

   localparam int LW = LEVEL_FRAC_BITS + 1;
   localparam int CNT_BITS = $clog2(LW + 1);
   localparam logic [LW-1:0] LEVEL_ONE = LW'(1) << LEVEL_FRAC_BITS;

   logic [LW-1:0]        q_ff, q_in;
   logic [TICK_BITS-1:0] rem_ff, rem_in;
   logic [TICK_BITS-1:0] div_ff, div_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [TICK_BITS:0]   shifted;
   logic [TICK_BITS:0]   diff;
   logic                 ge;

   always_comb begin
      shifted = {rem_ff, q_ff[LW-1]};
      diff = shifted - {1'b0, div_ff};
      ge = shifted >= {1'b0, div_ff};
      q_in = q_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = LEVEL_ONE;
         rem_in = '0;
         div_in = divisor;
         cnt_in = CNT_BITS'(LW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[TICK_BITS-1:0] : shifted[TICK_BITS-1:0];
         q_in = {q_ff[LW-2:0], ge};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

@@ src/toggle_linear_ar_envelope.sv @@
// Linear attack/release envelope driven by a toggle trigger.
// Each transaction on req_chan carries one audio tick with a trigger flag and
// produces exactly one transaction on rsp_chan with the envelope level in
// unsigned fixed point, where 1.0 is 1 << LEVEL_FRAC_BITS (low 24 bits shown).
// A trigger while idle or releasing starts an attack; a trigger while the
// attack phase is active starts a release. Durations are written as tick
// counts through the csr_ port: index 0 is the attack, index 1 the release.
// A tick without a trigger, or with a zero tick count, goes from idle straight
// to the update state, which registers its result once the output register is
// free, and then passes through a hold state before the next tick is taken. A
// trigger with a nonzero tick count computes the step with a restoring divider
// that retires one quotient bit a cycle, and the sequencer waits in the divide
// state until it is done before it updates; no new tick is taken meanwhile.
// The request side is ready only while the sequencer is idle. A finished
// result waits in the output register while the next tick is taken in; if
// the receiver is still stalling when that next result is ready, the block
// holds it until the output register drains.
// Reset is synchronous and active high; it restores both tick counts to 4800,
// the idle phase and a zero held level, step and tick counter.
`timescale 1ns / 1ps
`default_nettype none

module toggle_linear_ar_envelope
   import aenv_pkg::*;
#(
   parameter int LEVEL_FRAC_BITS = 23,
   parameter int TICK_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   aenv_req_if.sink                       req_chan,
   aenv_rsp_if.source                     rsp_chan,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int LW = LEVEL_FRAC_BITS + 1;
   localparam logic [LW-1:0] LEVEL_ONE = LW'(1) << LEVEL_FRAC_BITS;
   localparam logic [TICK_BITS-1:0] TICKS_INIT = TICKS_RESET[TICK_BITS-1:0];

   seq_state_type          state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [TICK_BITS-1:0]   attack_ff, attack_in;
   logic [TICK_BITS-1:0]   release_ff, release_in;
   logic [TICK_BITS-1:0]   ticks_left_ff, ticks_left_in;
   logic [LW-1:0]          step_ff, step_in;
   logic [LW-1:0]          held_ff, held_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0]  level_ff, level_in;

   logic                   req_take;
   logic                   commit;
   logic                   div_start;
   logic                   div_done;
   logic [LW-1:0]          div_quotient;
   logic [TICK_BITS-1:0]   load_ticks;
   phase_type              load_phase;
   logic [LW:0]            sum;
   logic [LW-1:0]          lvl;
   logic [LW+LEVEL_BITS-1:0] lvl_wide;

   aenv_div #(
      .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS),
      .TICK_BITS(TICK_BITS)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .divisor(load_ticks),
      .done(div_done),
      .quotient(div_quotient)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.level = level_ff;

   always_comb begin
      attack_in = attack_ff;
      release_in = release_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ATTACK_TICKS:  attack_in = csr_wdata[TICK_BITS-1:0];
            CSR_RELEASE_TICKS: release_in = csr_wdata[TICK_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      load_phase = (phase_ff == PHASE_ON) ? PHASE_OFF : PHASE_ON;
      load_ticks = (phase_ff == PHASE_ON) ? release_ff : attack_ff;
      div_start = req_take && req_chan.trigger && (load_ticks != '0);

      sum = {1'b0, held_ff} + {1'b0, step_ff};
      lvl = held_ff;
      if (ticks_left_ff == '0) begin
         lvl = (phase_ff == PHASE_ON) ? LEVEL_ONE : '0;
      end else if (phase_ff == PHASE_ON) begin
         lvl = (sum > {1'b0, LEVEL_ONE}) ? LEVEL_ONE : sum[LW-1:0];
      end else if (phase_ff == PHASE_OFF) begin
         lvl = (held_ff > step_ff) ? (held_ff - step_ff) : '0;
      end
      if (lvl > LEVEL_ONE) begin
         lvl = LEVEL_ONE;
      end
      lvl_wide = {{LEVEL_BITS{1'b0}}, lvl};

      commit = (state_ff == ST_UPDATE) && !(rsp_valid_ff && !rsp_chan.ready);

      state_in = state_ff;
      phase_in = phase_ff;
      ticks_left_in = ticks_left_ff;
      step_in = step_ff;
      held_in = held_ff;
      level_in = level_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_chan.trigger) begin
                  phase_in = load_phase;
                  ticks_left_in = load_ticks;
                  step_in = '0;
                  state_in = div_start ? ST_DIV : ST_UPDATE;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               step_in = div_quotient;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (commit) begin
               if (ticks_left_ff != '0) begin
                  ticks_left_in = ticks_left_ff - TICK_BITS'(1);
                  held_in = lvl;
               end
               level_in = lvl_wide[LEVEL_BITS-1:0];
               rsp_valid_in = 1'b1;
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PHASE_IDLE;
         attack_ff <= TICKS_INIT;
         release_ff <= TICKS_INIT;
         ticks_left_ff <= '0;
         step_ff <= '0;
         held_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         attack_ff <= attack_in;
         release_ff <= release_in;
         ticks_left_ff <= ticks_left_in;
         step_ff <= step_in;
         held_ff <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("Divider finished outside of the divide state.");

   a_held_in_range: assert property (@(posedge clock) disable iff (reset)
      (held_ff <= LEVEL_ONE) && (step_ff <= LEVEL_ONE))
      else $error("Held level or step exceeds full scale.");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff && (state_ff == ST_HOLD))
      else $error("Committed result did not reach the output register.");

endmodule

`default_nettype wire
